@@ rtl/core/rvss_pkg.sv @@
// rvss_pkg: shared constants, types and helpers of the rv32i subset core
// no dependencies; imported by rvss_front, rvss_back and the top level
`default_nettype none

package rvss_pkg;

  // memory geometry
  localparam int unsigned MEM_BYTES = 1048576;
  localparam int unsigned MEM_WORDS = MEM_BYTES / 4;
  localparam int unsigned ROW_W     = $clog2(MEM_WORDS);
  localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

  // reset values of the configuration registers
  localparam logic [31:0] START_RST = 32'h0000_008c;
  localparam logic [31:0] STACK_RST = 32'h0010_0000;

  // configuration register indexes
  localparam logic CFG_START_ADDR = 1'b0;
  localparam logic CFG_STACK_TOP  = 1'b1;

  // opcodes and function codes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [2:0] F3_ADD    = 3'd0;
  localparam logic [2:0] F3_LW     = 3'd2;
  localparam logic [2:0] F3_LBU    = 3'd4;
  localparam logic [2:0] F3_SB     = 3'd0;
  localparam logic [2:0] F3_SW     = 3'd2;
  localparam logic [6:0] F7_ADD    = 7'd0;
  localparam logic [31:0] INST_EBREAK = 32'h0010_0073;
  localparam logic [31:0] PC_HALT     = 32'hffff_ffff;
  localparam logic [31:0] LUI_MASK    = 32'hffff_f000;
  localparam logic [31:0] JALR_MASK   = 32'hffff_fffe;
  localparam logic [4:0]  REG_ZERO    = 5'd0;
  localparam logic [4:0]  REG_SP      = 5'd2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_EXEC    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RS_RUN      = 2'd0,
    RS_HALT     = 2'd1,
    RS_MISALIGN = 2'd2,
    RS_BADOP    = 2'd3
  } run_e;

  typedef enum logic [1:0] {
    SK_NONE = 2'd0,
    SK_BYTE = 2'd1,
    SK_WORD = 2'd2
  } store_e;

  // classified transaction passed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic        load_ok;
    logic [17:0] word_index;
    logic [31:0] word_data;
  } item_t;

  // run state after the pc changes
  function automatic run_e settle(input logic [31:0] pc, input run_e cur);
    run_e r;
    begin
      r = cur;
      if ({1'b0, pc} >= MEM_LIMIT) begin
        r = RS_HALT;
      end else if (pc[1:0] != 2'b00) begin
        r = RS_MISALIGN;
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/rvss_ram.sv @@
// rvss_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none

module rvss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/rvss_front.sv @@
// rvss_front: accepts input transactions, classifies them, two-entry queue
// depends on rvss_pkg
`default_nettype none

module rvss_front import rvss_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [17:0] word_index_i,
  input  wire  [31:0] word_data_i,
  input  wire         clr_busy_i,
  output logic        q_valid_o,
  output item_t       q_item_o,
  input  wire         q_pop_i
);

  item_t       ent_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  item_t       item_in;

  // classify the incoming transaction
  always_comb begin
    item_in.cmd        = cmd_e'(cmd_i);
    item_in.load_ok    = 32'(word_index_i) < MEM_WORDS;
    item_in.word_index = word_index_i;
    item_in.word_data  = word_data_i;
  end

  assign in_ready_o = !clr_busy_i && (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_item_o   = ent_q[rp_q];

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/rvss_back.sv @@
// rvss_back: executes queued transactions, holds memory, registers and pc
// depends on rvss_pkg and rvss_ram
`default_nettype none

module rvss_back import rvss_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         q_valid_i,
  input  item_t       q_item_i,
  output logic        q_pop_o,
  output logic        clr_busy_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] pc_out_o,
  output logic        rd_written_o,
  output logic [4:0]  rd_index_o,
  output logic [31:0] rd_value_o,
  output logic [1:0]  store_kind_o,
  output logic [31:0] store_address_o,
  output logic [31:0] store_data_o
);

  typedef enum logic [4:0] {
    BS_IDLE  = 5'b00001,
    BS_FETCH = 5'b00010,
    BS_REGS  = 5'b00100,
    BS_MEM   = 5'b01000,
    BS_DONE  = 5'b10000
  } bstate_e;

  bstate_e           state_q;
  logic              clr_q;
  logic [ROW_W-1:0]  clr_row_q;
  logic [31:0]       start_q, stack_q, sp_q, pc_q;
  run_e              run_q;
  logic [31:0]       rvld_q;
  logic              out_vld_q;

  logic [31:0] inst_q, addr_q, val_q, next_q;
  logic [3:0]  ok_q;
  logic        is_ld_q, ld_word_q, wrt_q, known_q;
  logic [4:0]  rd_q;
  logic        res_wr_q;
  logic [4:0]  res_idx_q;
  logic [31:0] res_val_q, res_sa_q, res_sd_q;
  store_e      res_sk_q;
  logic [1:0]  o_status_q, o_sk_q;
  logic [31:0] o_pc_q, o_val_q, o_sa_q, o_sd_q;
  logic        o_wr_q;
  logic [4:0]  o_idx_q;

  // lane ram ports
  logic             lane_we    [4];
  logic [ROW_W-1:0] lane_waddr [4];
  logic [7:0]       lane_wdata [4];
  logic [ROW_W-1:0] lane_raddr [4];
  logic [7:0]       lane_rdata [4];

  logic [31:0] fetch_word;
  logic [31:0] rf1_rdata, rf2_rdata;
  logic        rf_we;

  logic        pop;
  logic [ROW_W-1:0] ld_row;
  logic [31:0] wi32;

  // decode and execute signals
  logic [6:0]  op;
  logic [4:0]  rs1_idx, rs2_idx;
  logic [2:0]  f3;
  logic [31:0] rs1v, rs2v, immi, imms, mem_addr, next_pc, sum_rr;
  logic        is_store, st_en, st_word;
  logic [3:0]  ok;
  logic [1:0]  kj   [4];
  logic [ROW_W-1:0] st_row [4];
  logic        st_we [4];
  logic [7:0]  st_byte [4];
  logic [7:0]  rs2_b [4];
  logic        wrt, known, is_ld, ld_word;
  logic [31:0] val, nxt;
  store_e      sk;

  // load assembly signals
  logic [7:0]  ld_b [4];
  logic [31:0] ld_val, fin_val;

  assign pop        = (state_q == BS_IDLE) && !clr_q && q_valid_i;
  assign q_pop_o    = pop;
  assign clr_busy_o = clr_q;
  assign wi32       = 32'(q_item_i.word_index);
  assign ld_row     = wi32[ROW_W-1:0];
  assign fetch_word = {lane_rdata[3], lane_rdata[2], lane_rdata[1], lane_rdata[0]};

  // instruction fields and operands
  assign op      = inst_q[6:0];
  assign f3      = inst_q[14:12];
  assign rs1_idx = inst_q[19:15];
  assign rs2_idx = inst_q[24:20];
  assign rs1v    = rvld_q[rs1_idx] ? rf1_rdata : ((rs1_idx == REG_SP) ? sp_q : '0);
  assign rs2v    = rvld_q[rs2_idx] ? rf2_rdata : ((rs2_idx == REG_SP) ? sp_q : '0);
  assign immi    = {{20{inst_q[31]}}, inst_q[31:20]};
  assign imms    = {{20{inst_q[31]}}, inst_q[31:25], inst_q[11:7]};
  assign is_store = op == OP_STORE;
  assign mem_addr = rs1v + (is_store ? imms : immi);
  assign sum_rr   = rs1v + rs2v;
  assign next_pc  = pc_q + 32'd4;
  assign st_word  = f3 == F3_SW;
  assign st_en    = is_store && (st_word || (f3 == F3_SB));

  // byte lane mapping of a data access
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ok[k]    = {1'b0, mem_addr} < (MEM_LIMIT - 33'(k));
      rs2_b[k] = rs2v[8*k +: 8];
    end
    for (int j = 0; j < 4; j++) begin
      kj[j]      = 2'(j) - mem_addr[1:0];
      st_row[j]  = mem_addr[ROW_W+1:2] + ROW_W'(2'(j) < mem_addr[1:0]);
      st_we[j]   = st_en && ok[kj[j]] && (st_word || (kj[j] == 2'd0));
      st_byte[j] = rs2_b[kj[j]];
    end
  end

  // opcode decode
  always_comb begin
    wrt     = 1'b0;
    known   = 1'b1;
    is_ld   = 1'b0;
    ld_word = 1'b0;
    val     = '0;
    nxt     = next_pc;
    sk      = SK_NONE;
    case (op)
      OP_LUI: begin
        wrt = 1'b1;
        val = inst_q & LUI_MASK;
      end
      OP_IMM: begin
        if (f3 == F3_ADD) begin
          wrt = 1'b1;
          val = mem_addr;
        end
      end
      OP_REG: begin
        if (f3 == F3_ADD && inst_q[31:25] == F7_ADD) begin
          wrt = 1'b1;
          val = sum_rr;
        end
      end
      OP_LOAD: begin
        if (f3 == F3_LW || f3 == F3_LBU) begin
          wrt     = 1'b1;
          is_ld   = 1'b1;
          ld_word = f3 == F3_LW;
        end
      end
      OP_STORE: begin
        if (f3 == F3_SW) begin
          sk = SK_WORD;
        end else if (f3 == F3_SB) begin
          sk = SK_BYTE;
        end
      end
      OP_JALR: begin
        wrt = 1'b1;
        val = next_pc;
        nxt = mem_addr & JALR_MASK;
      end
      OP_SYSTEM: begin
        if (inst_q == INST_EBREAK) nxt = PC_HALT;
      end
      default: known = 1'b0;
    endcase
  end

  // load data assembly, out-of-range bytes read zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ld_b[k] = lane_rdata[2'(addr_q[1:0] + 2'(k))] & {8{ok_q[k]}};
    end
    ld_val  = ld_word_q ? {ld_b[3], ld_b[2], ld_b[1], ld_b[0]} : {24'd0, ld_b[0]};
    fin_val = is_ld_q ? ld_val : val_q;
  end

  assign rf_we = (state_q == BS_MEM) && known_q && wrt_q && (rd_q != REG_ZERO);

  // lane ram port selection
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      lane_we[j]    = 1'b0;
      lane_waddr[j] = st_row[j];
      lane_wdata[j] = st_byte[j];
      lane_raddr[j] = st_row[j];
      if (clr_q) begin
        lane_we[j]    = 1'b1;
        lane_waddr[j] = clr_row_q;
        lane_wdata[j] = '0;
      end else if (state_q == BS_IDLE) begin
        lane_raddr[j] = pc_q[ROW_W+1:2];
        if (pop && q_item_i.cmd == CMD_LOAD && q_item_i.load_ok) begin
          lane_we[j]    = 1'b1;
          lane_waddr[j] = ld_row;
          lane_wdata[j] = q_item_i.word_data[8*j +: 8];
        end
      end else if (state_q == BS_REGS) begin
        lane_we[j] = st_we[j];
      end
    end
  end

  // byte lanes of the memory
  for (genvar g = 0; g < 4; g++) begin : g_lane
    rvss_ram #(.WIDTH(8), .DEPTH(MEM_WORDS)) u_lane (
      .clk_i   (clk_i),
      .we_i    (lane_we[g]),
      .waddr_i (lane_waddr[g]),
      .wdata_i (lane_wdata[g]),
      .raddr_i (lane_raddr[g]),
      .rdata_o (lane_rdata[g])
    );
  end

  // register file, one copy per read port
  rvss_ram #(.WIDTH(32), .DEPTH(32)) u_rf1 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd_q),
    .wdata_i (fin_val),
    .raddr_i (fetch_word[19:15]),
    .rdata_o (rf1_rdata)
  );

  rvss_ram #(.WIDTH(32), .DEPTH(32)) u_rf2 (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rd_q),
    .wdata_i (fin_val),
    .raddr_i (fetch_word[24:20]),
    .rdata_o (rf2_rdata)
  );

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      clr_q     <= 1'b1;
      clr_row_q <= '0;
      start_q   <= START_RST;
      stack_q   <= STACK_RST;
      sp_q      <= STACK_RST;
      pc_q      <= START_RST;
      run_q     <= settle(START_RST, RS_RUN);
      rvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_ADDR: start_q <= cfg_wdata_i;
          CFG_STACK_TOP:  stack_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (clr_q) begin
        clr_row_q <= clr_row_q + ROW_W'(1);
        if (clr_row_q == ROW_W'(MEM_WORDS - 1)) clr_q <= 1'b0;
      end
      // result valid: set when a result is handed over, cleared when taken
      if (state_q == BS_DONE && (!out_vld_q || out_ready_i)) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        BS_IDLE: begin
          if (pop) begin
            state_q <= BS_DONE;
            case (q_item_i.cmd)
              CMD_RESTART: begin
                rvld_q <= '0;
                sp_q   <= stack_q;
                pc_q   <= start_q;
                run_q  <= settle(start_q, RS_RUN);
              end
              CMD_EXEC: begin
                if (run_q == RS_RUN) state_q <= BS_FETCH;
              end
              default: ;
            endcase
          end
        end
        BS_FETCH: state_q <= BS_REGS;
        BS_REGS:  state_q <= BS_MEM;
        BS_MEM: begin
          state_q <= BS_DONE;
          if (!known_q) begin
            run_q <= RS_BADOP;
          end else begin
            pc_q  <= next_q;
            run_q <= settle(next_q, run_q);
            if (rf_we) rvld_q[rd_q] <= 1'b1;
          end
        end
        BS_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            state_q <= BS_IDLE;
          end
        end
        default: state_q <= BS_IDLE;
      endcase
    end
  end

  // datapath and result registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      res_wr_q  <= 1'b0;
      res_idx_q <= '0;
      res_val_q <= '0;
      res_sk_q  <= SK_NONE;
      res_sa_q  <= '0;
      res_sd_q  <= '0;
    end
    if (state_q == BS_FETCH) inst_q <= fetch_word;
    if (state_q == BS_REGS) begin
      addr_q    <= mem_addr;
      ok_q      <= ok;
      is_ld_q   <= is_ld;
      ld_word_q <= ld_word;
      wrt_q     <= wrt;
      known_q   <= known;
      val_q     <= val;
      next_q    <= nxt;
      rd_q      <= inst_q[11:7];
      res_sk_q  <= sk;
      if (sk != SK_NONE) begin
        res_sa_q <= mem_addr;
        res_sd_q <= st_word ? rs2v : {24'd0, rs2v[7:0]};
      end
    end
    if (state_q == BS_MEM && rf_we) begin
      res_wr_q  <= 1'b1;
      res_idx_q <= rd_q;
      res_val_q <= fin_val;
    end
    if (state_q == BS_DONE && (!out_vld_q || out_ready_i)) begin
      o_status_q <= run_q;
      o_pc_q     <= pc_q;
      o_wr_q     <= res_wr_q;
      o_idx_q    <= res_idx_q;
      o_val_q    <= res_val_q;
      o_sk_q     <= res_sk_q;
      o_sa_q     <= res_sa_q;
      o_sd_q     <= res_sd_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = o_status_q;
  assign pc_out_o        = o_pc_q;
  assign rd_written_o    = o_wr_q;
  assign rd_index_o      = o_idx_q;
  assign rd_value_o      = o_val_q;
  assign store_kind_o    = o_sk_q;
  assign store_address_o = o_sa_q;
  assign store_data_o    = o_sd_q;

endmodule

`default_nettype wire

@@ rtl/core/rv32i_subset_core_step.sv @@
// rv32i_subset_core_step: top level, front queue feeding the execute back end
// sequence: a memory load, restart, ignored or stalled command goes from idle to done;
//   an executed instruction goes through fetch, register read, data access,
//   each through a registered-read ram, then writeback and result
// the back end takes the next command only back in idle, once its result register is free;
//   out_valid_o is registered, and a result may wait on out_ready_i
// reset: clears the 2^18-row memory row by row, in_ready_o low meanwhile
`default_nettype none

module rv32i_subset_core_step import rvss_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [31:0] cfg_wdata_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  cmd_i,
  input  wire  [17:0] word_index_i,
  input  wire  [31:0] word_data_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] pc_out_o,
  output logic        rd_written_o,
  output logic [4:0]  rd_index_o,
  output logic [31:0] rd_value_o,
  output logic [1:0]  store_kind_o,
  output logic [31:0] store_address_o,
  output logic [31:0] store_data_o
);

  logic  q_valid, q_pop, clr_busy;
  item_t q_item;

  // accept and classify
  rvss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .word_index_i (word_index_i),
    .word_data_i  (word_data_i),
    .clr_busy_i   (clr_busy),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item),
    .q_pop_i      (q_pop)
  );

  // execute
  rvss_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_item_i        (q_item),
    .q_pop_o         (q_pop),
    .clr_busy_o      (clr_busy),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .pc_out_o        (pc_out_o),
    .rd_written_o    (rd_written_o),
    .rd_index_o      (rd_index_o),
    .rd_value_o      (rd_value_o),
    .store_kind_o    (store_kind_o),
    .store_address_o (store_address_o),
    .store_data_o    (store_data_o)
  );

  // no transaction taken while memory is being cleared
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o) else $error("transaction accepted during clear");

  // a store never reports a register write
  a_store_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && store_kind_o != SK_NONE) |-> !rd_written_o)
    else $error("store with register write");

  // x0 is never reported as written
  a_rd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rd_written_o) |-> rd_index_o != REG_ZERO)
    else $error("write to x0 reported");

  // halted only with pc beyond memory
  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == RS_HALT) |-> ({1'b0, pc_out_o} >= MEM_LIMIT))
    else $error("halted with pc inside memory");

endmodule

`default_nettype wire
